FILE: rtl/core/gpt_pkg.sv
package gpt_pkg;

  localparam int PIN_W      = 6;
  localparam int DUR_W      = 32;
  localparam int CMD_W      = 2;
  localparam int PIN_REGS   = 4;
  localparam int PIN_IDX_W  = $clog2(PIN_REGS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PIN_W;
  localparam int OUT_CH     = 4;
  localparam int CHANNELS_DEF = 4;

  localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PULSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // decoded command for the channels; set and pulse are qualified by match, pulse also by duration
  typedef struct packed {
    logic set;
    logic pulse;
    logic tick;
  } gpt_ctl_t;

endpackage

FILE: rtl/core/gpt_in_if.sv
interface gpt_in_if import gpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [PIN_W-1:0] pin;
  logic             value;
  logic [DUR_W-1:0] duration;

  modport source (output valid, cmd, pin, value, duration, input ready);
  modport sink   (input valid, cmd, pin, value, duration, output ready);
endinterface

FILE: rtl/core/gpt_out_if.sv
interface gpt_out_if import gpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [OUT_CH-1:0] levels;
  logic [OUT_CH-1:0] pulses_active;

  modport source (output valid, accepted, levels, pulses_active, input ready);
  modport sink   (input valid, accepted, levels, pulses_active, output ready);
endinterface

FILE: rtl/core/gpio_pulse_timer.sv
// An accepted beat goes into the input register, then into the result register.
// Throughput: one beat per cycle unless out_ch.ready stalls the result register;
// the channel state registers update between the input and result registers.
// Reset (rst_n, synchronous, active low): all levels low, no pulses running,
// pin registers back to 0..3, both pipeline registers empty.
module gpio_pulse_timer import gpt_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gpt_in_if.sink                in_ch,
  gpt_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [PIN_W-1:0]    pin_r [PIN_REGS];

  logic                s1_v_r;
  logic [CMD_W-1:0]    s1_cmd_r;
  logic [PIN_W-1:0]    s1_pin_r;
  logic                s1_value_r;
  logic [DUR_W-1:0]    s1_dur_r;

  logic                out_v_r;
  logic                out_acc_r;
  logic [OUT_CH-1:0]   out_lvl_r;
  logic [OUT_CH-1:0]   out_pls_r;

  logic                adv;
  logic                step;
  logic                in_fire;
  logic [CHANNELS-1:0] hit;
  logic                any_hit;
  gpt_ctl_t            ctl;
  logic [CHANNELS-1:0] lvl_nxt;
  logic [CHANNELS-1:0] pls_nxt;
  logic [OUT_CH-1:0]   lvl_out;
  logic [OUT_CH-1:0]   pls_out;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIN_REGS; i++) begin
        pin_r[i] <= PIN_W'(i);
      end
    end else if (cfg_we && (cfg_idx < CFG_IDX_W'(PIN_REGS))) begin
      pin_r[cfg_idx[PIN_IDX_W-1:0]] <= cfg_wdata[PIN_W-1:0];
    end
  end

  // handshake: result register frees when empty or taken
  assign adv          = !out_v_r || out_ch.ready;
  assign step         = s1_v_r && adv;
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= in_ch.cmd;
      s1_pin_r   <= in_ch.pin;
      s1_value_r <= in_ch.value;
      s1_dur_r   <= in_ch.duration;
    end
  end

  gpt_match #(.CHANNELS(CHANNELS)) u_match (
    .pin      (s1_pin_r),
    .pin_regs (pin_r),
    .hit      (hit),
    .any_hit  (any_hit)
  );

  assign ctl.set   = (s1_cmd_r == CMD_SET) && any_hit;
  assign ctl.pulse = (s1_cmd_r == CMD_PULSE) && any_hit && (s1_dur_r != '0);
  assign ctl.tick  = (s1_cmd_r == CMD_TICK);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    gpt_chan u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (step),
      .ctl       (ctl),
      .sel       (hit[c]),
      .value     (s1_value_r),
      .duration  (s1_dur_r),
      .level_nxt (lvl_nxt[c]),
      .pulse_nxt (pls_nxt[c])
    );
  end

  for (genvar b = 0; b < OUT_CH; b++) begin : g_out
    if (b < CHANNELS) begin : g_live
      assign lvl_out[b] = lvl_nxt[b];
      assign pls_out[b] = pls_nxt[b];
    end else begin : g_none
      assign lvl_out[b] = 1'b0;
      assign pls_out[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_acc_r <= ctl.set || ctl.pulse || ctl.tick;
      out_lvl_r <= lvl_out;
      out_pls_r <= pls_out;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.accepted      = out_acc_r;
  assign out_ch.levels        = out_lvl_r;
  assign out_ch.pulses_active = out_pls_r;

  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("more than one channel selected");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r && out_v_r && !out_ch.ready)
    else $error("input stalled with room in the pipeline");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r && $stable(s1_cmd_r) && $stable(s1_pin_r))
    else $error("input register changed while stalled");

endmodule

FILE: rtl/core/gpt_match.sv
module gpt_match import gpt_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic [PIN_W-1:0]    pin,
  input  logic [PIN_W-1:0]    pin_regs [PIN_REGS],
  output logic [CHANNELS-1:0] hit,
  output logic                any_hit
);

  logic [CHANNELS-1:0] match;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_cmp
    if (c < PIN_REGS) begin : g_reg
      assign match[c] = (pin_regs[c] == pin);
    end else begin : g_fixed
      // channels without a register answer to their own number
      assign match[c] = (pin == PIN_W'(c));
    end
  end

  // keep only the lowest matching channel
  assign hit     = match & ~(match - CHANNELS'(1));
  assign any_hit = |match;

endmodule

FILE: rtl/core/gpt_chan.sv
module gpt_chan import gpt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  gpt_ctl_t         ctl,
  input  logic             sel,
  input  logic             value,
  input  logic [DUR_W-1:0] duration,
  output logic             level_nxt,
  output logic             pulse_nxt
);

  logic             level_r;
  logic             restore_r;
  logic             pulse_r;
  logic [DUR_W-1:0] rem_r;
  logic             restore_nxt;
  logic [DUR_W-1:0] rem_nxt;
  logic [DUR_W-1:0] rem_dec;

  assign rem_dec = (rem_r != '0) ? rem_r - DUR_W'(1) : rem_r;

  always_comb begin
    level_nxt   = level_r;
    restore_nxt = restore_r;
    pulse_nxt   = pulse_r;
    rem_nxt     = rem_r;
    if (ctl.set && sel) begin
      level_nxt = value;
      pulse_nxt = 1'b0;
    end else if (ctl.pulse && sel) begin
      // a retrigger keeps the level saved by the first pulse
      if (!pulse_r) begin
        restore_nxt = level_r;
      end
      level_nxt = value;
      rem_nxt   = duration;
      pulse_nxt = 1'b1;
    end else if (ctl.tick && pulse_r) begin
      rem_nxt = rem_dec;
      if (rem_dec == '0) begin
        level_nxt = restore_r;
        pulse_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      pulse_r <= 1'b0;
    end else if (en) begin
      level_r <= level_nxt;
      pulse_r <= pulse_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      restore_r <= restore_nxt;
      rem_r     <= rem_nxt;
    end
  end

  a_pulse_has_time: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r |-> rem_r != '0)
    else $error("running pulse with zero remaining time");

  a_pulse_start: assert property (@(posedge clk) disable iff (!rst_n)
    en && !pulse_r && pulse_nxt |-> ctl.pulse && sel)
    else $error("pulse started without a pulse command");

endmodule
